/* hw/rtl/sal_pkg.sv */
// ----------------------------------------------------------------------------
// sal_pkg: shared types and codes for the sequential array list
// Item and result layouts, operation and status codes, controller commands.
// ----------------------------------------------------------------------------
package sal_pkg;

	localparam int OP_W     = 3;
	localparam int POS_W    = 6;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 3;

	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
	localparam logic [OP_W-1:0] OP_READ   = 3'd2;
	localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]         op;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic signed [VAL_W-1:0] value_out;
		logic [POS_W-1:0]        found_position;
		logic [POS_W-1:0]        item_count;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_INS_SHIFT,
		S_INS_PUT,
		S_READ,
		S_REM_FIRST,
		S_REM_SHIFT,
		S_REM_END,
		S_SRCH
	} ctl_state_t;

	typedef enum logic [3:0] {
		STEP_NONE,
		STEP_INS_BEGIN,
		STEP_INS_SHIFT,
		STEP_INS_PUT,
		STEP_POS_BEGIN,
		STEP_READ_DONE,
		STEP_REM_FIRST,
		STEP_REM_SHIFT,
		STEP_REM_END,
		STEP_SRCH_BEGIN,
		STEP_SRCH
	} step_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC,
		CNT_CLEAR
	} cnt_t;

	typedef struct packed {
		logic                accept;
		step_t               step;
		logic                finish;
		logic [STATUS_W-1:0] status;
		cnt_t                cnt;
	} ctl_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            full;
		logic            empty;
		logic            pos_bad;
		logic            ins_append;
		logic            ins_last;
		logic            rem_first_last;
		logic            rem_shift_last;
		logic            srch_last;
		logic            match;
	} sts_t;

endpackage

/* hw/rtl/sal_ram.sv */
// ----------------------------------------------------------------------------
// sal_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* hw/rtl/sal_ctrl.sv */
// ----------------------------------------------------------------------------
// sal_ctrl: operation sequencer
// Decodes each item and steps the datapath through shift, read or scan.
// ----------------------------------------------------------------------------
module sal_ctrl
	import sal_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output ctl_t ctl,
	output logic busy
);

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_IDLE;
				case (sts.op)
					OP_INSERT: begin
						if (!sts.full) begin
							state_d = sts.ins_append ? S_INS_PUT : S_INS_SHIFT;
						end
					end
					OP_REMOVE: begin
						if (!sts.empty && !sts.pos_bad) begin
							state_d = S_REM_FIRST;
						end
					end
					OP_READ: begin
						if (!sts.empty && !sts.pos_bad) begin
							state_d = S_READ;
						end
					end
					OP_SEARCH: begin
						if (!sts.empty) begin
							state_d = S_SRCH;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_INS_SHIFT: begin
				if (sts.ins_last) begin
					state_d = S_INS_PUT;
				end
			end
			S_INS_PUT:   state_d = S_IDLE;
			S_READ:      state_d = S_IDLE;
			S_REM_FIRST: state_d = sts.rem_first_last ? S_REM_END : S_REM_SHIFT;
			S_REM_SHIFT: begin
				if (sts.rem_shift_last) begin
					state_d = S_REM_END;
				end
			end
			S_REM_END:   state_d = S_IDLE;
			S_SRCH: begin
				if (sts.match || sts.srch_last) begin
					state_d = S_IDLE;
				end
			end
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl        = '0;
		ctl.step   = STEP_NONE;
		ctl.status = ST_OK;
		ctl.cnt    = CNT_HOLD;
		case (state_q)
			S_IDLE: ctl.accept = start;
			S_DISPATCH: begin
				case (sts.op)
					OP_INSERT: begin
						if (sts.full) begin
							ctl.finish = 1'b1;
							ctl.status = ST_FULL;
						end else begin
							ctl.step = STEP_INS_BEGIN;
						end
					end
					OP_REMOVE, OP_READ: begin
						if (sts.empty) begin
							ctl.finish = 1'b1;
							ctl.status = ST_EMPTY;
						end else if (sts.pos_bad) begin
							ctl.finish = 1'b1;
							ctl.status = ST_BADPOS;
						end else begin
							ctl.step = STEP_POS_BEGIN;
						end
					end
					OP_SEARCH: begin
						if (sts.empty) begin
							ctl.finish = 1'b1;
							ctl.status = ST_EMPTY;
						end else begin
							ctl.step = STEP_SRCH_BEGIN;
						end
					end
					OP_CLEAR: begin
						ctl.finish = 1'b1;
						ctl.status = sts.empty ? ST_EMPTY : ST_OK;
						ctl.cnt    = CNT_CLEAR;
					end
					default: ctl.finish = 1'b1;
				endcase
			end
			S_INS_SHIFT: ctl.step = STEP_INS_SHIFT;
			S_INS_PUT: begin
				ctl.step   = STEP_INS_PUT;
				ctl.finish = 1'b1;
				ctl.cnt    = CNT_INC;
			end
			S_READ: begin
				ctl.step   = STEP_READ_DONE;
				ctl.finish = 1'b1;
			end
			S_REM_FIRST: ctl.step = STEP_REM_FIRST;
			S_REM_SHIFT: ctl.step = STEP_REM_SHIFT;
			S_REM_END: begin
				ctl.step   = STEP_REM_END;
				ctl.finish = 1'b1;
				ctl.cnt    = CNT_DEC;
			end
			S_SRCH: begin
				ctl.step   = STEP_SRCH;
				ctl.finish = sts.match || sts.srch_last;
				ctl.status = sts.match ? ST_OK : ST_NOTFOUND;
			end
			default: ctl.step = STEP_NONE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	a_finish_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |-> state_q != S_IDLE)
		else $error("finish raised while idle");

	a_finish_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |=> state_q == S_IDLE)
		else $error("sequencer did not return to idle after finish");

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept |=> state_q == S_DISPATCH)
		else $error("accepted item not dispatched");

endmodule

/* hw/rtl/sal_dp.sv */
// ----------------------------------------------------------------------------
// sal_dp: list datapath
// Holds the item, the count, the walk pointer, the store and the result.
// ----------------------------------------------------------------------------
module sal_dp
	import sal_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  ctl_t    ctl,
	output sts_t    sts,
	output logic    done,
	output result_t result
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;
	localparam int XW   = (CW > POS_W) ? CW : POS_W;

	logic [OP_W-1:0]  op_q;
	logic [POS_W-1:0] pos_q;
	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] vout_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    idx_q;
	logic             done_q;
	result_t          result_q;

	logic [CW-1:0]    count_d;
	logic [AW-1:0]    idx_d;
	logic [AW-1:0]    ins_at;
	logic [CMPW-1:0]  pos_x;
	logic [CMPW-1:0]  cnt_x;
	logic [CW-1:0]    idx_p1;
	logic [CW-1:0]    idx_p2;
	logic [XW-1:0]    count_w;
	logic [VAL_W-1:0] vout_d;
	logic [POS_W-1:0] found_d;

	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [VAL_W-1:0] wr_data;
	logic [AW-1:0]    rd_addr;
	logic [VAL_W-1:0] rd_data;

	sal_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign pos_x  = CMPW'(pos_q);
	assign cnt_x  = CMPW'(count_q);
	assign idx_p1 = CW'(idx_q) + CW'(1);
	assign idx_p2 = CW'(idx_q) + CW'(2);
	assign ins_at = (pos_x >= cnt_x) ? AW'(count_q) : AW'(pos_q);

	always_comb begin
		sts                = '0;
		sts.op             = op_q;
		sts.full           = (count_q == CW'(DEPTH));
		sts.empty          = (count_q == '0);
		sts.pos_bad        = (pos_x == '0) || (pos_x > cnt_x);
		sts.ins_append     = (pos_x >= cnt_x);
		sts.ins_last       = ((idx_q - AW'(1)) == ins_at);
		sts.rem_first_last = (idx_p1 == count_q);
		sts.rem_shift_last = (idx_p2 == count_q);
		sts.srch_last      = (idx_p1 == count_q);
		sts.match          = (rd_data == val_q);
	end

	always_comb begin
		idx_d   = idx_q;
		rd_addr = idx_q;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_data;
		case (ctl.step)
			STEP_INS_BEGIN: begin
				idx_d   = AW'(count_q);
				rd_addr = AW'(count_q) - AW'(1);
			end
			STEP_INS_SHIFT: begin
				wr_en   = 1'b1;
				idx_d   = idx_q - AW'(1);
				rd_addr = idx_q - AW'(2);
			end
			STEP_INS_PUT: begin
				wr_en   = 1'b1;
				wr_data = val_q;
			end
			STEP_POS_BEGIN: begin
				idx_d   = AW'(pos_q) - AW'(1);
				rd_addr = AW'(pos_q) - AW'(1);
			end
			STEP_REM_FIRST: rd_addr = idx_q + AW'(1);
			STEP_REM_SHIFT: begin
				wr_en   = 1'b1;
				idx_d   = idx_q + AW'(1);
				rd_addr = idx_q + AW'(2);
			end
			STEP_SRCH_BEGIN: begin
				idx_d   = '0;
				rd_addr = '0;
			end
			STEP_SRCH: begin
				idx_d   = idx_q + AW'(1);
				rd_addr = idx_q + AW'(1);
			end
			default: idx_d = idx_q;
		endcase
	end

	always_comb begin
		case (ctl.cnt)
			CNT_INC:   count_d = count_q + CW'(1);
			CNT_DEC:   count_d = count_q - CW'(1);
			CNT_CLEAR: count_d = '0;
			default:   count_d = count_q;
		endcase
	end

	assign count_w = XW'(count_d);

	always_comb begin
		case (ctl.step)
			STEP_READ_DONE: vout_d = rd_data;
			STEP_REM_END:   vout_d = vout_q;
			default:        vout_d = '0;
		endcase
	end

	assign found_d = (ctl.step == STEP_SRCH && ctl.status == ST_OK) ?
		POS_W'(idx_p1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= ctl.finish;
			if (ctl.finish) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			op_q  <= item.op;
			pos_q <= item.position;
			val_q <= item.value;
		end
		idx_q <= idx_d;
		if (ctl.step == STEP_REM_FIRST) begin
			vout_q <= rd_data;
		end
		if (ctl.finish) begin
			result_q.status         <= ctl.status;
			result_q.value_out      <= vout_d;
			result_q.found_position <= found_d;
			result_q.item_count     <= count_w[POS_W-1:0];
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("count exceeds depth");

	a_count_only_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(ctl.finish) |-> $stable(count_q))
		else $error("count changed outside finish");

endmodule

/* hw/rtl/sequential_array_list_core.sv */
// ----------------------------------------------------------------------------
// sequential_array_list_core: bounded packed list of signed 32-bit words
// Insert, remove, read, search and clear on a list held in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Drive item (op, position, value) and raise start; the item is taken at a
//   clock edge where start is high and busy is low. busy stays high until the
//   operation has finished.
//   One result per item appears on result for exactly one cycle with done
//   high; the receiver cannot stall, so it must take it in that cycle.
//   Error cases, clear and unused ops finish at dispatch; read finishes after
//   one RAM read. Insert shifts the entries from the end of the list down to
//   the insert index, remove shifts those after the position down by one, and
//   search walks from the first entry until a match or the end of the list.
//   The walk is set by the single RAM read port: one entry per cycle.
//   A new item may be accepted in the cycle its predecessor shows done.
//   Reset empties the list; the RAM contents are not cleared and need no pass.
// ----------------------------------------------------------------------------
module sequential_array_list_core
	import sal_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	ctl_t ctl;
	sts_t sts;

	sal_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.ctl   (ctl),
		.busy  (busy)
	);

	sal_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.ctl   (ctl),
		.sts   (sts),
		.done  (done),
		.result(result)
	);

endmodule

/* tb/sequential_array_list_core_tb.sv */
// ----------------------------------------------------------------------------
// sequential_array_list_core_tb: self-checking bench for the array list core
// A queue of commands feeds a bursty driver. A shadow list predicts each
// result when its item is taken, and the monitor checks every done strobe
// against the oldest prediction. A short directed run covers the empty, bad
// position, append, duplicate and reserved-op cases. Random phases then
// fill, drain and mix the list, drawing values from a small pool so that
// searches hit.
// ----------------------------------------------------------------------------
module sequential_array_list_core_tb;
	import sal_pkg::*;

	localparam int DEPTH    = 32;
	localparam int N_RANDOM = 1050;
	localparam int IDLE_MAX = 2000;
	localparam int TAIL     = 2 * DEPTH;

	localparam logic [OP_W-1:0] OP_RSVD_A = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD_B = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD_C = 3'd7;

	typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} gen_mode_t;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   cmd    = '0;
	logic    busy;
	logic    done;
	result_t res;

	item_t   cmd_q[$];
	result_t answer_q[$];

	logic signed [VAL_W-1:0] words [DEPTH];
	int      n_words = 0;
	int      plan_len = 0;
	logic [VAL_W-1:0] common_words [8];

	int      burst_left = 0;
	int      gap_left   = 0;
	int      idle_cycles = 0;
	int      n_taken    = 0;
	int      n_checked  = 0;
	int      n_errors   = 0;
	int      status_seen [8];

	sequential_array_list_core #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (cmd),
		.done  (done),
		.result(res)
	);

	always #4 clk = ~clk;

	function automatic result_t list_apply(input item_t it);
		result_t r;
		int      idx;
		int      i;
		r = '0;
		r.status = ST_OK;
		idx = int'(it.position);
		case (it.op)
		OP_INSERT: begin
			if (n_words >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				if (idx > n_words)
					idx = n_words;
				for (i = n_words; i > idx; i--)
					words[i] = words[i-1];
				words[idx] = it.value;
				n_words++;
			end
		end
		OP_REMOVE, OP_READ: begin
			if (n_words == 0) begin
				r.status = ST_EMPTY;
			end else if (idx == 0 || idx > n_words) begin
				r.status = ST_BADPOS;
			end else begin
				r.value_out = words[idx-1];
				if (it.op == OP_REMOVE) begin
					for (i = idx; i < n_words; i++)
						words[i-1] = words[i];
					n_words--;
				end
			end
		end
		OP_SEARCH: begin
			if (n_words == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.status = ST_NOTFOUND;
				for (i = 0; i < n_words; i++) begin
					if (words[i] == it.value) begin
						r.status = ST_OK;
						r.found_position = POS_W'(i + 1);
						break;
					end
				end
			end
		end
		OP_CLEAR: begin
			if (n_words == 0)
				r.status = ST_EMPTY;
			else
				n_words = 0;
		end
		default: ;
		endcase
		r.item_count = POS_W'(n_words);
		return r;
	endfunction

	function automatic void queue_cmd(input logic [OP_W-1:0] op, input int pos,
		input logic [VAL_W-1:0] val);
		item_t it;
		it.op = op;
		it.position = POS_W'(pos);
		it.value = val;
		cmd_q.push_back(it);
		case (op)
		OP_INSERT: if (plan_len < DEPTH) plan_len++;
		OP_REMOVE: if (pos >= 1 && pos <= plan_len) plan_len--;
		OP_CLEAR:  plan_len = 0;
		default: ;
		endcase
	endfunction

	// driver: hold the item until taken, then advance in bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				answer_q.push_back(list_apply(cmd));
				n_taken++;
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (cmd_q.size() > 0) begin
					cmd <= cmd_q.pop_front();
					start <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
							: $urandom_range(1, 8);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: check each strobe against the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (answer_q.size() == 0) begin
				$display("%0t: unexpected result: status %0d value_out %0d found %0d count %0d",
					$time, res.status, res.value_out, res.found_position, res.item_count);
				n_errors++;
			end else begin
				want = answer_q.pop_front();
				n_checked++;
				status_seen[want.status]++;
				if (res.status !== want.status) begin
					$display("%0t: status: expected %0d, actual %0d",
						$time, want.status, res.status);
					n_errors++;
				end
				if (res.value_out !== want.value_out) begin
					$display("%0t: value_out: expected %0d, actual %0d",
						$time, want.value_out, res.value_out);
					n_errors++;
				end
				if (res.found_position !== want.found_position) begin
					$display("%0t: found_position: expected %0d, actual %0d",
						$time, want.found_position, res.found_position);
					n_errors++;
				end
				if (res.item_count !== want.item_count) begin
					$display("%0t: item_count: expected %0d, actual %0d",
						$time, want.item_count, res.item_count);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || (arst_n && done))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_MAX) begin
			$display("%0t: timeout, %0d items pending, %0d results outstanding",
				$time, cmd_q.size(), answer_q.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int                n_rand;
		int                roll;
		int                phase_left;
		int                pos;
		int                p_ins;
		int                p_rem;
		int                p_rd;
		int                p_sr;
		gen_mode_t         mode;
		logic [OP_W-1:0]   op;
		logic [VAL_W-1:0]  val;

		foreach (status_seen[k])
			status_seen[k] = 0;
		common_words[0] = 32'h8000_0000;
		common_words[1] = 32'h7fff_ffff;
		common_words[2] = 32'h0000_0000;
		common_words[3] = 32'hffff_ffff;
		for (int k = 4; k < 8; k++)
			common_words[k] = $urandom;

		queue_cmd(OP_READ, 1, 32'd5);
		queue_cmd(OP_REMOVE, 1, 32'd5);
		queue_cmd(OP_SEARCH, 0, 32'h0000_0000);
		queue_cmd(OP_CLEAR, 0, 32'd0);
		queue_cmd(OP_INSERT, 63, 32'h7fff_ffff);
		queue_cmd(OP_INSERT, 0, 32'h8000_0000);
		queue_cmd(OP_INSERT, 1, 32'h0000_0000);
		queue_cmd(OP_INSERT, 3, 32'hffff_ffff);
		queue_cmd(OP_INSERT, 40, 32'h0000_0000);
		queue_cmd(OP_READ, 0, 32'd0);
		queue_cmd(OP_READ, 6, 32'd0);
		queue_cmd(OP_READ, 5, 32'd0);
		queue_cmd(OP_READ, 1, 32'd0);
		queue_cmd(OP_SEARCH, 0, 32'h0000_0000);
		queue_cmd(OP_SEARCH, 0, 32'hffff_ffff);
		queue_cmd(OP_SEARCH, 63, 32'd12345);
		queue_cmd(OP_REMOVE, 0, 32'd0);
		queue_cmd(OP_REMOVE, 63, 32'd0);
		queue_cmd(OP_REMOVE, 5, 32'd0);
		queue_cmd(OP_REMOVE, 1, 32'd0);
		queue_cmd(OP_RSVD_A, 63, 32'hffff_ffff);
		queue_cmd(OP_RSVD_B, 1, 32'd0);
		queue_cmd(OP_RSVD_C, 0, 32'h7fff_ffff);
		queue_cmd(OP_CLEAR, 63, 32'hffff_ffff);
		queue_cmd(OP_READ, 1, 32'd0);

		n_rand = 0;
		phase_left = 0;
		mode = MODE_FILL;
		while (n_rand < N_RANDOM) begin
			if (phase_left == 0) begin
				case ($urandom_range(0, 2))
				0: mode = MODE_FILL;
				1: mode = MODE_DRAIN;
				default: mode = MODE_MIX;
				endcase
				phase_left = $urandom_range(40, 100);
			end
			phase_left--;
			case (mode)
			MODE_FILL: begin
				p_ins = 70; p_rem = 8; p_rd = 10; p_sr = 10;
			end
			MODE_DRAIN: begin
				p_ins = 10; p_rem = 60; p_rd = 12; p_sr = 16;
			end
			default: begin
				p_ins = 35; p_rem = 25; p_rd = 18; p_sr = 19;
			end
			endcase
			roll = $urandom_range(0, 99);
			if (roll < p_ins)
				op = OP_INSERT;
			else if (roll < p_ins + p_rem)
				op = OP_REMOVE;
			else if (roll < p_ins + p_rem + p_rd)
				op = OP_READ;
			else if (roll < p_ins + p_rem + p_rd + p_sr)
				op = OP_SEARCH;
			else if ($urandom_range(0, 1) == 0)
				op = OP_CLEAR;
			else begin
				case ($urandom_range(0, 2))
				0: op = OP_RSVD_A;
				1: op = OP_RSVD_B;
				default: op = OP_RSVD_C;
				endcase
			end

			pos = $urandom_range(0, 63);
			if (op == OP_INSERT && $urandom_range(0, 99) < 85)
				pos = $urandom_range(0, plan_len);
			else if ((op == OP_REMOVE || op == OP_READ) && plan_len > 0
				&& $urandom_range(0, 99) < 85)
				pos = $urandom_range(1, plan_len);

			val = ($urandom_range(0, 99) < 60) ? common_words[$urandom_range(0, 7)]
				: $urandom;

			if (op != OP_RSVD_A && op != OP_RSVD_B && op != OP_RSVD_C)
				n_rand++;
			queue_cmd(op, pos, val);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (cmd_q.size() != 0 || start || answer_q.size() != 0);
		repeat (TAIL) @(posedge clk);

		$display("Issued %0d items and checked %0d results.", n_taken, n_checked);
		$display("Outcomes: %0d ok, %0d bad position, %0d full, %0d empty, %0d not found.",
			status_seen[ST_OK], status_seen[ST_BADPOS], status_seen[ST_FULL],
			status_seen[ST_EMPTY], status_seen[ST_NOTFOUND]);
		if (n_errors == 0 && answer_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
